/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/fqr_pkg.sv */
package fqr_pkg;

   localparam int CMD_W    = 2;
   localparam int ID_IN_W  = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

/* rtl/core/fqr_req_if.sv */
interface fqr_req_if
   import fqr_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ID_IN_W-1:0] proc_id;

   modport source (output valid, output command, output proc_id, input ready);
   modport sink   (input valid, input command, input proc_id, output ready);
endinterface

/* rtl/core/fqr_rsp_if.sv */
interface fqr_rsp_if
   import fqr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_IN_W-1:0]  removed_id;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output removed_id, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input removed_id, input occupancy,
                   output ready);
endinterface

/* rtl/core/fifo_queue_with_remove_by_id_top.sv */
// Channel   Dir  Word fields                             Handshake
// req_chan  in   command[1:0], proc_id[7:0]              valid / ready
// rsp_chan  out  status[1:0], removed_id[7:0], occ[4:0]  valid / ready
//
// Add, ignored codes and any remove on an empty queue go straight to the done state, which
// loads the result word; remove-first first passes the pop state (one registered RAM read
// of the head). Remove-by-id reads one RAM entry per cycle from the head to the match, then
// the same read port and the write port slide later entries one slot forward.
// Ready is high only while the sequencer is idle; a result word waiting in the output
// register does not block the next accept, only the loading of the next result.
// Reset (synchronous) empties the queue at once; the RAM needs no clearing pass.
`include "assert_macros.svh"

module fifo_queue_with_remove_by_id_top
   import fqr_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int ID_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   fqr_req_if.sink    req_chan,
   fqr_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_POP   = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type           state_ff,      state_in;
   logic [CW-1:0]       count_ff,      count_in;
   logic [AW-1:0]       head_ff,       head_in;
   logic [AW-1:0]       tail_ff,       tail_in;
   logic [AW-1:0]       rd_ptr_ff,     rd_ptr_in;
   logic [AW-1:0]       wr_ptr_ff,     wr_ptr_in;
   logic [CW-1:0]       pos_ff,        pos_in;
   logic [ID_WIDTH-1:0] key_ff,        key_in;
   status_type          res_status_ff, res_status_in;
   logic [ID_WIDTH-1:0] res_id_ff,     res_id_in;

   logic                rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_IN_W-1:0]  rsp_id_ff,     rsp_id_in;
   logic [OCC_W-1:0]    rsp_occ_ff,    rsp_occ_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ID_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [ID_WIDTH-1:0] ram_rdata;

   logic                        req_fire;
   logic                        at_last;
   logic [ID_WIDTH+ID_IN_W-1:0] req_id_wide;
   logic [ID_WIDTH-1:0]         req_id;
   logic [ID_WIDTH+ID_IN_W-1:0] res_id_wide;
   logic [CW+OCC_W-1:0]         occ_wide;

   // Circular pointer advance with wrap at DEPTH
   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   fqr_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Mask the incoming identifier to ID_WIDTH bits, zero-extending if wider
   assign req_id_wide = {{ID_WIDTH{1'b0}}, req_chan.proc_id};
   assign req_id      = req_id_wide[ID_WIDTH-1:0];

   // Entry under the read port is the last one held
   assign at_last = (pos_ff + 1'b1) == count_ff;

   // Result fields are truncated to their port widths
   assign res_id_wide = {{ID_IN_W{1'b0}}, res_id_ff};
   assign occ_wide    = {{OCC_W{1'b0}}, count_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_wdata     = ram_rdata;
      // Read one slot ahead so data streams every cycle during scan and slide
      ram_raddr     = ptr_next(rd_ptr_ff);

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in        = req_id;
               res_status_in = ST_OK;
               res_id_in     = '0;
               state_in      = S_DONE;
               unique case (cmd_type'(req_chan.command))
                  CMD_ADD: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // write at tail directly from the request word
                        ram_we    = 1'b1;
                        ram_waddr = tail_ff;
                        ram_wdata = req_id;
                        tail_in   = ptr_next(tail_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        ram_raddr = head_ff;
                        state_in  = S_POP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        ram_raddr = head_ff;
                        rd_ptr_in = head_ff;
                        pos_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  CMD_NOP: begin
                     // ignored code: report occupancy only
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_POP: begin
            res_id_in = ram_rdata;
            head_in   = ptr_next(head_ff);
            count_in  = count_ff - 1'b1;
            state_in  = S_DONE;
         end

         S_SCAN: begin
            rd_ptr_in = ptr_next(rd_ptr_ff);
            pos_in    = pos_ff + 1'b1;
            if (ram_rdata == key_ff) begin
               res_id_in = ram_rdata;
               if (at_last) begin
                  // match on the tail entry: drop it, nothing to slide
                  count_in = count_ff - 1'b1;
                  tail_in  = rd_ptr_ff;
                  state_in = S_DONE;
               end else begin
                  wr_ptr_in = rd_ptr_ff;
                  state_in  = S_SHIFT;
               end
            end else if (at_last) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end

         S_SHIFT: begin
            // move the entry under the read port one slot toward the head
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_ff;
            ram_wdata = ram_rdata;
            wr_ptr_in = rd_ptr_ff;
            rd_ptr_in = ptr_next(rd_ptr_ff);
            pos_in    = pos_ff + 1'b1;
            if (at_last) begin
               count_in = count_ff - 1'b1;
               tail_in  = rd_ptr_ff;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the output register is free, then load the word
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_wide[ID_IN_W-1:0];
               rsp_occ_in    = occ_wide[OCC_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.removed_id = rsp_id_ff;
   assign rsp_chan.occupancy  = rsp_occ_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `ASSERT_IMPLY(a_pos_in_range, clock, reset,
                 state_ff == S_SCAN || state_ff == S_SHIFT, pos_ff < count_ff, "walk past tail")
   `ASSERT_NEXT(a_add_grows, clock, reset,
                req_fire && req_chan.command == CMD_ADD && count_ff != CW'(DEPTH),
                count_ff == CW'($past(count_ff) + 1'b1), "add lost")
   `ASSERT_IMPLY(a_fail_no_id, clock, reset,
                 rsp_valid_ff && rsp_status_ff != ST_OK, rsp_id_ff == '0, "id on failed word")

endmodule

/* rtl/core/fqr_ram.sv */
module fqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
